// ===== sv/cbe_pkg.sv =====
package cbe_pkg;

  localparam int SampleW = 24;
  localparam int AlphaW  = 16;
  localparam int PowerW  = 16;
  localparam int NormW   = 32;
  localparam int RegionW = 2;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  // ln2 and 1/ln2 in Q30, and 1.0 in Q30
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] INV_LN2_Q30 = 31'd1549082005;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  typedef enum logic [2:0] {
    CFG_ALPHA_LOW       = 3'd0,
    CFG_ALPHA_HIGH      = 3'd1,
    CFG_TAIL_POWER_LOW  = 3'd2,
    CFG_TAIL_POWER_HIGH = 3'd3,
    CFG_PEAK_MEAN       = 3'd4,
    CFG_PEAK_SIGMA      = 3'd5,
    CFG_NORM_SCALE      = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REG_CORE      = 2'd0,
    REG_LOW_TAIL  = 2'd1,
    REG_HIGH_TAIL = 2'd2
  } region_t;

  // per-item context that rides along the pipeline
  typedef struct packed {
    logic        neg;
    logic        core;
    logic [22:0] lcore;
  } ctx_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    logic [63:0] rem;
    int s;
    res = '0;
    bit_w = 64'h4000_0000_0000_0000;
    rem = v;
    for (s = 0; s < 32; s++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-i) in Q30 by repeated square roots of 0.5
  function automatic logic [30:0] exp_root(input int i);
    logic [63:0] r;
    int j;
    r = 64'h2000_0000;
    for (j = 1; j <= 16; j++) begin
      if (j <= i) begin
        r = isqrt64(r << 30);
      end
    end
    return r[30:0];
  endfunction

endpackage

// ===== sv/cbe_if.sv =====
interface cbe_in_if import cbe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_x;

  modport source (output valid, output sample_x, input ready);
  modport sink (input valid, input sample_x, output ready);
endinterface

interface cbe_out_if import cbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NormW-1:0]   shape_value;
  logic [RegionW-1:0] region;
  logic               saturated;

  modport source (output valid, output shape_value, output region, output saturated,
                  input ready);
  modport sink (input valid, input shape_value, input region, input saturated,
                output ready);
endinterface

// ===== sv/crystal_ball_evaluator.sv =====
// double-sided crystal ball shape evaluator
// in_ch carries one signed Q4.20 sample per transfer (valid/ready); out_ch returns
// one result per sample, in order: norm times shape in Q16.16, the region
// (core, low tail, high tail) and a saturation flag.
// shape parameters live in seven APB registers at byte offsets 0,4,..,24; write
// them only while no sample is in flight.
// throughput is one sample per cycle while out_ch is not stalled: the two long
// dividers (one quotient bit per stage), the 16 log2 squaring stages and the 16
// exp multiply stages are all pipelined with one stage per step.
// a synchronous low rst_n clears all valid bits and loads the register
// defaults; no clearing pass is needed.
// when out_ch.ready is low with a result waiting, the whole pipeline holds and
// in_ch.ready drops in the same cycle; nothing is dropped or repeated.
module crystal_ball_evaluator import cbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  cbe_in_if.sink              in_ch,
  cbe_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int DaSteps = 40;
  localparam int DbSteps = 56;
  localparam int LgSteps = 16;
  localparam int ExSteps = 16;

  // configuration registers
  logic [AlphaW-1:0]         alpha_low_r, alpha_high_r;
  logic [PowerW-1:0]         tail_power_low_r, tail_power_high_r;
  logic signed [SampleW-1:0] peak_mean_r;
  logic [SampleW-1:0]        peak_sigma_r;
  logic [NormW-1:0]          norm_scale_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r       <= 16'd4096;
      alpha_high_r      <= 16'd4096;
      tail_power_low_r  <= 16'd512;
      tail_power_high_r <= 16'd512;
      peak_mean_r       <= 24'sd1048576;
      peak_sigma_r      <= 24'd52429;
      norm_scale_r      <= 32'd65536;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(paddr[4:2]))
        CFG_ALPHA_LOW:       alpha_low_r       <= pwdata[15:0];
        CFG_ALPHA_HIGH:      alpha_high_r      <= pwdata[15:0];
        CFG_TAIL_POWER_LOW:  tail_power_low_r  <= pwdata[15:0];
        CFG_TAIL_POWER_HIGH: tail_power_high_r <= pwdata[15:0];
        CFG_PEAK_MEAN:       peak_mean_r       <= pwdata[23:0];
        CFG_PEAK_SIGMA:      peak_sigma_r      <= pwdata[23:0];
        CFG_NORM_SCALE:      norm_scale_r      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_t'(paddr[4:2]))
      CFG_ALPHA_LOW:       prdata = {16'b0, alpha_low_r};
      CFG_ALPHA_HIGH:      prdata = {16'b0, alpha_high_r};
      CFG_TAIL_POWER_LOW:  prdata = {16'b0, tail_power_low_r};
      CFG_TAIL_POWER_HIGH: prdata = {16'b0, tail_power_high_r};
      CFG_PEAK_MEAN:       prdata = {8'b0, peak_mean_r};
      CFG_PEAK_SIGMA:      prdata = {8'b0, peak_sigma_r};
      CFG_NORM_SCALE:      prdata = norm_scale_r;
      default:             prdata = '0;
    endcase
  end

  logic [SampleW-1:0] sig_eff;
  logic [PowerW-1:0]  tpl_eff, tph_eff;
  assign sig_eff = (peak_sigma_r == '0) ? 24'd1 : peak_sigma_r;
  assign tpl_eff = (tail_power_low_r == '0) ? 16'd1 : tail_power_low_r;
  assign tph_eff = (tail_power_high_r == '0) ? 16'd1 : tail_power_high_r;

  // pipeline advance
  logic out_v_r;
  logic adv, in_acc;
  assign adv = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc = in_ch.valid && adv;

  // valid bits
  logic [DaSteps:0] da_v_r;
  logic             c_v_r;
  logic [DbSteps:0] db_v_r;
  logic             l0_v_r, l1_v_r;
  logic [LgSteps:0] ls_v_r;
  logic             ln_v_r, nl_v_r, lsum_v_r;
  logic [ExSteps:0] xm_v_r;
  logic             sh_v_r, nm_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      da_v_r   <= '0;
      c_v_r    <= 1'b0;
      db_v_r   <= '0;
      l0_v_r   <= 1'b0;
      l1_v_r   <= 1'b0;
      ls_v_r   <= '0;
      ln_v_r   <= 1'b0;
      nl_v_r   <= 1'b0;
      lsum_v_r <= 1'b0;
      xm_v_r   <= '0;
      sh_v_r   <= 1'b0;
      nm_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (adv) begin
      da_v_r   <= {da_v_r[DaSteps-1:0], in_acc};
      c_v_r    <= da_v_r[DaSteps];
      db_v_r   <= {db_v_r[DbSteps-1:0], c_v_r};
      l0_v_r   <= db_v_r[DbSteps];
      l1_v_r   <= l0_v_r;
      ls_v_r   <= {ls_v_r[LgSteps-1:0], l1_v_r};
      ln_v_r   <= ls_v_r[LgSteps];
      nl_v_r   <= ln_v_r;
      lsum_v_r <= nl_v_r;
      xm_v_r   <= {xm_v_r[ExSteps-1:0], lsum_v_r};
      sh_v_r   <= xm_v_r[ExSteps];
      nm_v_r   <= sh_v_r;
      out_v_r  <= nm_v_r;
    end
  end

  // offset from the mean and its magnitude
  logic signed [SampleW:0] dif_nxt;
  logic [SampleW-1:0]      ad_nxt;
  assign dif_nxt = $signed({in_ch.sample_x[SampleW-1], in_ch.sample_x})
                 - $signed({peak_mean_r[SampleW-1], peak_mean_r});
  assign ad_nxt = dif_nxt[SampleW] ? SampleW'(-dif_nxt) : dif_nxt[SampleW-1:0];

  // |t| = (|d| << 16) / sigma, one quotient bit per stage
  logic [39:0] da_num_r [0:DaSteps];
  logic [23:0] da_rem_r [0:DaSteps];
  logic [39:0] da_quo_r [0:DaSteps];
  logic        da_neg_r [0:DaSteps];

  always_ff @(posedge clk) begin
    if (adv) begin
      da_num_r[0] <= {ad_nxt, 16'b0};
      da_rem_r[0] <= '0;
      da_quo_r[0] <= '0;
      da_neg_r[0] <= dif_nxt[SampleW];
    end
  end

  for (genvar j = 1; j <= DaSteps; j++) begin : g_da
    logic [24:0] trial_nxt;
    logic        take_nxt;
    assign trial_nxt = {da_rem_r[j-1], da_num_r[j-1][39]};
    assign take_nxt = trial_nxt >= {1'b0, sig_eff};
    always_ff @(posedge clk) begin
      if (adv) begin
        da_rem_r[j] <= take_nxt ? 24'(trial_nxt - {1'b0, sig_eff}) : trial_nxt[23:0];
        da_num_r[j] <= {da_num_r[j-1][38:0], 1'b0};
        da_quo_r[j] <= {da_quo_r[j-1][38:0], take_nxt};
        da_neg_r[j] <= da_neg_r[j-1];
      end
    end
  end

  // region decision
  logic [39:0]       mag;
  logic [AlphaW-1:0] c_a_nxt;
  logic [19:0]       c_a4_nxt;
  logic              c_neg_r, c_core_r;
  logic [19:0]       c_msq_r;
  logic [39:0]       c_dt_r;
  assign mag = da_quo_r[DaSteps];
  assign c_a_nxt = da_neg_r[DaSteps] ? alpha_low_r : alpha_high_r;
  assign c_a4_nxt = {c_a_nxt, 4'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      c_neg_r  <= da_neg_r[DaSteps];
      c_core_r <= mag <= {20'b0, c_a4_nxt};
      c_msq_r  <= mag[19:0];
      c_dt_r   <= mag - {20'b0, c_a4_nxt};
    end
  end

  // core square and tail numerator a*dt
  logic [AlphaW-1:0] d_a_nxt;
  logic [39:0]       d_sq_nxt;
  logic [55:0]       d_num_nxt;
  ctx_t              d_ctx_nxt;
  assign d_a_nxt = c_neg_r ? alpha_low_r : alpha_high_r;
  assign d_sq_nxt = {20'b0, c_msq_r} * {20'b0, c_msq_r};
  assign d_num_nxt = {40'b0, d_a_nxt} * {16'b0, c_dt_r};
  always_comb begin
    d_ctx_nxt.neg   = c_neg_r;
    d_ctx_nxt.core  = c_core_r;
    d_ctx_nxt.lcore = d_sq_nxt[39:17];
  end

  // q = a*dt / n, one quotient bit per stage
  logic [55:0] db_num_r [0:DbSteps];
  logic [15:0] db_rem_r [0:DbSteps];
  logic [55:0] db_quo_r [0:DbSteps];
  ctx_t        db_ctx_r [0:DbSteps];

  always_ff @(posedge clk) begin
    if (adv) begin
      db_num_r[0] <= d_num_nxt;
      db_rem_r[0] <= '0;
      db_quo_r[0] <= '0;
      db_ctx_r[0] <= d_ctx_nxt;
    end
  end

  for (genvar j = 1; j <= DbSteps; j++) begin : g_db
    logic [PowerW-1:0] n_nxt;
    logic [16:0]       trial_nxt;
    logic              take_nxt;
    assign n_nxt = db_ctx_r[j-1].neg ? tpl_eff : tph_eff;
    assign trial_nxt = {db_rem_r[j-1], db_num_r[j-1][55]};
    assign take_nxt = trial_nxt >= {1'b0, n_nxt};
    always_ff @(posedge clk) begin
      if (adv) begin
        db_rem_r[j] <= take_nxt ? 16'(trial_nxt - {1'b0, n_nxt}) : trial_nxt[15:0];
        db_num_r[j] <= {db_num_r[j-1][54:0], 1'b0};
        db_quo_r[j] <= {db_quo_r[j-1][54:0], take_nxt};
        db_ctx_r[j] <= db_ctx_r[j-1];
      end
    end
  end

  // log base, msb search, normalize
  logic [52:0] l0_base_r, l1_base_r;
  ctx_t        l0_ctx_r, l1_ctx_r;
  logic [5:0]  l1_p_nxt, l1_p_r;
  logic [63:0] l2_nb_nxt;

  always_comb begin
    l1_p_nxt = '0;
    for (int b = 16; b < 53; b++) begin
      if (l0_base_r[b]) l1_p_nxt = 6'(b);
    end
  end

  always_comb begin
    if (l1_p_r >= 6'd30) l2_nb_nxt = {11'b0, l1_base_r} >> (l1_p_r - 6'd30);
    else l2_nb_nxt = {11'b0, l1_base_r} << (6'd30 - l1_p_r);
  end

  logic [30:0] ls_m_r    [0:LgSteps];
  logic [15:0] ls_frac_r [0:LgSteps];
  logic [5:0]  ls_p_r    [0:LgSteps];
  ctx_t        ls_ctx_r  [0:LgSteps];

  always_ff @(posedge clk) begin
    if (adv) begin
      l0_base_r    <= 53'd65536 + {1'b0, db_quo_r[DbSteps][55:4]};
      l0_ctx_r     <= db_ctx_r[DbSteps];
      l1_base_r    <= l0_base_r;
      l1_p_r       <= l1_p_nxt;
      l1_ctx_r     <= l0_ctx_r;
      ls_m_r[0]    <= l2_nb_nxt[30:0];
      ls_frac_r[0] <= '0;
      ls_p_r[0]    <= l1_p_r;
      ls_ctx_r[0]  <= l1_ctx_r;
    end
  end

  // log2 fraction, one bit per squaring
  for (genvar i = 1; i <= LgSteps; i++) begin : g_ls
    logic [61:0] sq_nxt;
    logic [31:0] t_nxt;
    logic [15:0] frac_nxt;
    assign sq_nxt = {31'b0, ls_m_r[i-1]} * {31'b0, ls_m_r[i-1]};
    assign t_nxt = sq_nxt[61:30];
    always_comb begin
      frac_nxt = ls_frac_r[i-1];
      frac_nxt[LgSteps-i] = t_nxt[31];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ls_m_r[i]    <= t_nxt[31] ? t_nxt[31:1] : t_nxt[30:0];
        ls_frac_r[i] <= frac_nxt;
        ls_p_r[i]    <= ls_p_r[i-1];
        ls_ctx_r[i]  <= ls_ctx_r[i-1];
      end
    end
  end

  // ln, then L for the tail, then pick core or tail
  logic [21:0]       ln_l2_nxt;
  logic [51:0]       ln_prod_nxt;
  logic [21:0]       ln_r;
  ctx_t              ln_ctx_r;
  logic [AlphaW-1:0] nl_a_nxt;
  logic [PowerW-1:0] nl_n_nxt;
  logic [37:0]       nl_prod_nxt;
  logic [31:0]       aa_prod_nxt;
  logic [29:0]       nl_r;
  logic [22:0]       aa_r;
  ctx_t              nl_ctx_r;
  logic [30:0]       lsum_r;
  ctx_t              lsum_ctx_r;

  assign ln_l2_nxt = {6'(ls_p_r[LgSteps] - 6'd16), ls_frac_r[LgSteps]};
  assign ln_prod_nxt = {30'b0, ln_l2_nxt} * {22'b0, LN2_Q30};
  assign nl_a_nxt = ln_ctx_r.neg ? alpha_low_r : alpha_high_r;
  assign nl_n_nxt = ln_ctx_r.neg ? tpl_eff : tph_eff;
  assign nl_prod_nxt = {22'b0, nl_n_nxt} * {16'b0, ln_r};
  assign aa_prod_nxt = {16'b0, nl_a_nxt} * {16'b0, nl_a_nxt};

  always_ff @(posedge clk) begin
    if (adv) begin
      ln_r       <= ln_prod_nxt[51:30];
      ln_ctx_r   <= ls_ctx_r[LgSteps];
      nl_r       <= nl_prod_nxt[37:8];
      aa_r       <= aa_prod_nxt[31:9];
      nl_ctx_r   <= ln_ctx_r;
      lsum_r     <= nl_ctx_r.core ? {8'b0, nl_ctx_r.lcore} : {8'b0, aa_r} + {1'b0, nl_r};
      lsum_ctx_r <= nl_ctx_r;
    end
  end

  // exp(-L): y = L/ln2, then one root multiply per fraction bit
  logic [52:0] x0_prod_nxt;
  assign x0_prod_nxt = {31'b0, lsum_r[21:0]} * {22'b0, INV_LN2_Q30};

  logic [30:0] xm_m_r    [0:ExSteps];
  logic [22:0] xm_y_r    [0:ExSteps];
  logic        xm_zero_r [0:ExSteps];
  ctx_t        xm_ctx_r  [0:ExSteps];

  always_ff @(posedge clk) begin
    if (adv) begin
      xm_m_r[0]    <= ONE_Q30;
      xm_y_r[0]    <= x0_prod_nxt[52:30];
      xm_zero_r[0] <= |lsum_r[30:22];
      xm_ctx_r[0]  <= lsum_ctx_r;
    end
  end

  for (genvar i = 1; i <= ExSteps; i++) begin : g_xm
    localparam logic [30:0] Root = exp_root(i);
    logic [61:0] prod_nxt;
    assign prod_nxt = {31'b0, xm_m_r[i-1]} * {31'b0, Root};
    always_ff @(posedge clk) begin
      if (adv) begin
        xm_m_r[i]    <= xm_y_r[i-1][ExSteps-i] ? prod_nxt[60:30] : xm_m_r[i-1];
        xm_y_r[i]    <= xm_y_r[i-1];
        xm_zero_r[i] <= xm_zero_r[i-1];
        xm_ctx_r[i]  <= xm_ctx_r[i-1];
      end
    end
  end

  // integer shift, norm scale, clip
  logic [6:0]  sh_k_nxt;
  logic [30:0] sh_shape_r;
  ctx_t        sh_ctx_r;
  logic [62:0] nm_prod_nxt;
  logic [32:0] nm_val_r;
  ctx_t        nm_ctx_r;
  region_t     out_reg_nxt;

  assign sh_k_nxt = xm_y_r[ExSteps][22:16];
  assign nm_prod_nxt = {31'b0, norm_scale_r} * {32'b0, sh_shape_r};

  always_comb begin
    if (nm_ctx_r.core) out_reg_nxt = REG_CORE;
    else if (nm_ctx_r.neg) out_reg_nxt = REG_LOW_TAIL;
    else out_reg_nxt = REG_HIGH_TAIL;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_shape_r <= (xm_zero_r[ExSteps] || sh_k_nxt > 7'd30) ? '0
                  : xm_m_r[ExSteps] >> sh_k_nxt;
      sh_ctx_r   <= xm_ctx_r[ExSteps];
      nm_val_r   <= nm_prod_nxt[62:30];
      nm_ctx_r   <= sh_ctx_r;
      out_ch.shape_value <= nm_val_r[32] ? '1 : nm_val_r[31:0];
      out_ch.saturated   <= nm_val_r[32];
      out_ch.region      <= out_reg_nxt;
    end
  end

  assign out_ch.valid = out_v_r;

`ifndef SYNTH
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |-> out_ch.shape_value == '1)
    else $error("saturated result not at maximum");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && db_v_r == '0)
    else $error("valid bits survive reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |=> $stable(db_v_r) && $stable(xm_v_r))
    else $error("pipeline moved during stall");
`endif

endmodule
